@@ sv/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helpers for barometric pressure compensation.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned DivW  = 32;
    localparam int unsigned SideW = 64;
    localparam int unsigned IdxW  = 3;

    localparam logic [IdxW-1:0] RegAc1Ac2 = 3'd0;
    localparam logic [IdxW-1:0] RegAc3Ac4 = 3'd1;
    localparam logic [IdxW-1:0] RegAc5Ac6 = 3'd2;
    localparam logic [IdxW-1:0] RegB1B2   = 3'd3;
    localparam logic [IdxW-1:0] RegMcMd   = 3'd4;
    localparam logic [IdxW-1:0] RegOss    = 3'd5;

    localparam logic [1:0]       OssReset = 2'd3;
    localparam logic [DataW-1:0] TOff     = 32'd4000;
    localparam logic [DataW-1:0] KRound   = 32'd32768;
    localparam logic [DataW-1:0] KScale   = 32'd50000;
    localparam logic [DataW-1:0] K3038    = 32'd3038;
    localparam logic [DataW-1:0] KNeg7357 = 32'hFFFF_E343;
    localparam logic [DataW-1:0] K3791    = 32'd3791;
    localparam logic [DataW-1:0] KTRound  = 32'd8;
    localparam logic [DataW-1:0] KQRound  = 32'd2;
    localparam logic [DataW-1:0] KNegAdj  = 32'd3;

    typedef logic [SideW-1:0] t_side;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } t_cal;

    typedef struct packed {
        logic [31:0] x1;
        logic        neg;
        logic        zero;
        logic [23:0] up;
        logic [5:0]  pad;
    } t_tside;

    typedef struct packed {
        logic [15:0] temp;
        logic        fault;
        logic        msb;
        logic [45:0] pad;
    } t_pside;

    function automatic logic [DataW-1:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [DataW-1:0] zx16(input logic [15:0] x);
        return {16'b0, x};
    endfunction

endpackage

@@ sv/bpc_div.sv @@
// ----------------------------------------------------------------------------
// bpc_div
// Pipelined unsigned 32-bit divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [DataW-1:0] i_num,
    input  logic [DataW-1:0] i_den,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [DataW-1:0] o_quo,
    output t_side            o_side
);

    logic             r_vld  [DivW];
    logic [DataW-1:0] r_rem  [DivW];
    logic [DataW-1:0] r_num  [DivW];
    logic [DataW-1:0] r_den  [DivW];
    t_side            r_side [DivW];

    logic             n_vld  [DivW];
    logic [DataW-1:0] n_rem  [DivW];
    logic [DataW-1:0] n_num  [DivW];
    logic [DataW-1:0] n_den  [DivW];
    t_side            n_side [DivW];

    always_comb begin
        logic [DataW-1:0] s_rem;
        logic [DataW-1:0] s_num;
        logic [DataW:0]   s_trial;
        for (int k = 0; k < DivW; k++) begin
            if (k == 0) begin
                n_vld[k]  = i_valid;
                s_rem     = '0;
                s_num     = i_num;
                n_den[k]  = i_den;
                n_side[k] = i_side;
            end else begin
                n_vld[k]  = r_vld[k-1];
                s_rem     = r_rem[k-1];
                s_num     = r_num[k-1];
                n_den[k]  = r_den[k-1];
                n_side[k] = r_side[k-1];
            end
            s_trial = {s_rem, s_num[DataW-1]} - {1'b0, n_den[k]};
            if (!s_trial[DataW]) begin
                n_rem[k] = s_trial[DataW-1:0];
                n_num[k] = {s_num[DataW-2:0], 1'b1};
            end else begin
                n_rem[k] = {s_rem[DataW-2:0], s_num[DataW-1]};
                n_num[k] = {s_num[DataW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DivW; k++) begin
            r_rem[k]  <= n_rem[k];
            r_num[k]  <= n_num[k];
            r_den[k]  <= n_den[k];
            r_side[k] <= n_side[k];
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    assign o_valid = r_vld[DivW-1];
    assign o_quo   = r_num[DivW-1];
    assign o_side  = r_side[DivW-1];

endmodule

@@ sv/bpc_regs.sv @@
// ----------------------------------------------------------------------------
// bpc_regs
// Calibration and oversampling register file behind the write channel.
// ----------------------------------------------------------------------------
module bpc_regs import bpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [IdxW-1:0]  i_cfg_index,
    input  logic [DataW-1:0] i_cfg_data,
    output logic             o_cfg_ready,
    output t_cal             o_cal
);

    t_cal r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal     <= '0;
            r_cal.oss <= OssReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegAc1Ac2: {r_cal.ac1, r_cal.ac2} <= i_cfg_data;
                RegAc3Ac4: {r_cal.ac3, r_cal.ac4} <= i_cfg_data;
                RegAc5Ac6: {r_cal.ac5, r_cal.ac6} <= i_cfg_data;
                RegB1B2:   {r_cal.b1, r_cal.b2}   <= i_cfg_data;
                RegMcMd:   {r_cal.mc, r_cal.md}   <= i_cfg_data;
                RegOss:    r_cal.oss              <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cal       = r_cal;

endmodule

@@ sv/barometric_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Pipelined temperature and pressure compensation from raw sensor words.
//
// channel  | handshake              | payload
// ---------+------------------------+--------------------------------------
// input    | i_start / o_busy       | i_raw_temperature, i_raw_pressure
// result   | o_valid strobe         | o_temperature_centi, o_pressure_pa,
//          |                        | o_divide_fault
// config   | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// one item per cycle; results leave in the order their items were taken
// the path holds two 32-stage divider pipelines plus 14 arithmetic stages
// o_busy stays low; the pipeline never stalls since results cannot be held
// synchronous active-low reset clears valid bits and calibration words and loads OssReset into the oss configuration
// ----------------------------------------------------------------------------
module barometric_pressure_compensation import bpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [15:0]        i_raw_temperature,
    input  logic [23:0]        i_raw_pressure,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IdxW-1:0]    i_cfg_index,
    input  logic [DataW-1:0]   i_cfg_data,
    output logic               o_valid,
    output logic signed [15:0] o_temperature_centi,
    output logic [17:0]        o_pressure_pa,
    output logic               o_divide_fault
);

    function automatic logic [15:0] sat16(input logic [DataW-1:0] x);
        logic signed [DataW-1:0] s;
        s = $signed(x);
        if (s > 32'sd32767) begin
            return 16'h7FFF;
        end else if (s < -32'sd32768) begin
            return 16'h8000;
        end
        return x[15:0];
    endfunction

    function automatic logic [DataW-1:0] asr(input logic [DataW-1:0] x,
                                             input int unsigned n);
        return DataW'($signed(x) >>> n);
    endfunction

    t_cal cal;
    logic [DataW-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    bpc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cal       (cal)
    );

    assign ac1 = sx16(cal.ac1);
    assign ac2 = sx16(cal.ac2);
    assign ac3 = sx16(cal.ac3);
    assign ac4 = zx16(cal.ac4);
    assign ac5 = zx16(cal.ac5);
    assign ac6 = zx16(cal.ac6);
    assign b1  = sx16(cal.b1);
    assign b2  = sx16(cal.b2);
    assign mc  = sx16(cal.mc);
    assign md  = sx16(cal.md);

    assign o_busy = 1'b0;

    // temperature front
    logic             r1_vld;
    logic [DataW-1:0] r1_mt;
    logic [23:0]      r1_up;
    logic [DataW-1:0] d_t;

    assign d_t = zx16(i_raw_temperature) - ac6;

    always_ff @(posedge i_clk) begin
        r1_mt <= d_t * ac5;
        r1_up <= i_raw_pressure;
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_start;
        end
    end

    logic             ra_vld;
    logic [DataW-1:0] ra_x1, ra_den;
    logic [23:0]      ra_up;
    logic [DataW-1:0] x1_t;

    assign x1_t = asr(r1_mt, 15);

    always_ff @(posedge i_clk) begin
        ra_x1  <= x1_t;
        ra_den <= x1_t + md;
        ra_up  <= r1_up;
        if (!i_rst_n) begin
            ra_vld <= 1'b0;
        end else begin
            ra_vld <= r1_vld;
        end
    end

    // temperature division
    logic [DataW-1:0] tnum, tnum_abs, tden_abs, tq;
    t_tside           ts_in, ts_out;
    t_side            tside_o;
    logic             tdv_vld;

    assign tnum     = DataW'(mc << 11);
    assign tnum_abs = tnum[DataW-1] ? (~tnum + 1'b1) : tnum;
    assign tden_abs = ra_den[DataW-1] ? (~ra_den + 1'b1) : ra_den;
    assign ts_in    = '{x1: ra_x1, neg: tnum[DataW-1] ^ ra_den[DataW-1],
                        zero: (ra_den == '0), up: ra_up, pad: '0};

    bpc_div u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ra_vld),
        .i_num   (tnum_abs),
        .i_den   (tden_abs),
        .i_side  (t_side'(ts_in)),
        .o_valid (tdv_vld),
        .o_quo   (tq),
        .o_side  (tside_o)
    );

    assign ts_out = t_tside'(tside_o);

    // pressure arithmetic
    logic             r4_vld, r4_zero;
    logic [DataW-1:0] r4_b5;
    logic [23:0]      r4_up;

    always_ff @(posedge i_clk) begin
        r4_b5   <= ts_out.x1 + (ts_out.neg ? (~tq + 1'b1) : tq);
        r4_zero <= ts_out.zero;
        r4_up   <= ts_out.up;
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= tdv_vld;
        end
    end

    logic             r5_vld, r5_zero;
    logic [DataW-1:0] r5_b6, r5_t;
    logic [23:0]      r5_up;

    always_ff @(posedge i_clk) begin
        r5_b6   <= r4_b5 - TOff;
        r5_t    <= DataW'(r4_b5 << 3) + DataW'(r4_b5 << 1) + KTRound;
        r5_zero <= r4_zero;
        r5_up   <= r4_up;
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    logic             r6_vld, r6_zero;
    logic [DataW-1:0] r6_sqp, r6_a2, r6_a3;
    logic [15:0]      r6_t;
    logic [23:0]      r6_up;

    always_ff @(posedge i_clk) begin
        r6_sqp  <= r5_b6 * r5_b6;
        r6_a2   <= ac2 * r5_b6;
        r6_a3   <= ac3 * r5_b6;
        r6_t    <= sat16(asr(r5_t, 4));
        r6_zero <= r5_zero;
        r6_up   <= r5_up;
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    logic             r7_vld, r7_zero;
    logic [DataW-1:0] r7_b2, r7_b1, r7_x2, r7_x1c, sq;
    logic [15:0]      r7_t;
    logic [23:0]      r7_up;

    assign sq = asr(r6_sqp, 12);

    always_ff @(posedge i_clk) begin
        r7_b2   <= b2 * sq;
        r7_b1   <= b1 * sq;
        r7_x2   <= asr(r6_a2, 11);
        r7_x1c  <= asr(r6_a3, 13);
        r7_t    <= r6_t;
        r7_zero <= r6_zero;
        r7_up   <= r6_up;
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    logic             r8_vld, r8_zero;
    logic [DataW-1:0] r8_s, r8_w;
    logic [15:0]      r8_t;
    logic [23:0]      r8_up;

    always_ff @(posedge i_clk) begin
        r8_s    <= DataW'(ac1 << 2) + asr(r7_b2, 11) + r7_x2;
        r8_w    <= asr(r7_x1c + asr(r7_b1, 16) + KQRound, 2) + KRound;
        r8_t    <= r7_t;
        r8_zero <= r7_zero;
        r8_up   <= r7_up;
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= r7_vld;
        end
    end

    logic             r9_vld, r9_zero;
    logic [DataW-1:0] r9_b3, r9_b4p, r9_ups, v_b3;
    logic [15:0]      r9_t;

    assign v_b3 = DataW'(r8_s << cal.oss) + KQRound;

    always_ff @(posedge i_clk) begin
        r9_b3   <= asr(v_b3 + (v_b3[DataW-1] ? KNegAdj : '0), 2);
        r9_b4p  <= ac4 * r8_w;
        r9_ups  <= {8'b0, r8_up} >> (4'd8 - {2'b0, cal.oss});
        r9_t    <= r8_t;
        r9_zero <= r8_zero;
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= r8_vld;
        end
    end

    logic             r10_vld, r10_zero;
    logic [DataW-1:0] r10_b4, r10_diff;
    logic [15:0]      r10_t;

    always_ff @(posedge i_clk) begin
        r10_b4   <= r9_b4p >> 15;
        r10_diff <= r9_ups - r9_b3;
        r10_t    <= r9_t;
        r10_zero <= r9_zero;
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else begin
            r10_vld <= r9_vld;
        end
    end

    logic             r11_vld, r11_fault;
    logic [DataW-1:0] r11_b7, r11_b4;
    logic [15:0]      r11_t;

    always_ff @(posedge i_clk) begin
        r11_b7    <= r10_diff * (KScale >> cal.oss);
        r11_b4    <= r10_b4;
        r11_fault <= r10_zero | (r10_b4 == '0);
        r11_t     <= r10_t;
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
        end else begin
            r11_vld <= r10_vld;
        end
    end

    // pressure division
    logic [DataW-1:0] pnum, pq, p;
    t_pside           ps_in, ps_out;
    t_side            pside_o;
    logic             pdv_vld;

    assign pnum  = r11_b7[DataW-1] ? r11_b7 : DataW'(r11_b7 << 1);
    assign ps_in = '{temp: r11_t, fault: r11_fault, msb: r11_b7[DataW-1], pad: '0};

    bpc_div u_pdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r11_vld),
        .i_num   (pnum),
        .i_den   (r11_b4),
        .i_side  (t_side'(ps_in)),
        .o_valid (pdv_vld),
        .o_quo   (pq),
        .o_side  (pside_o)
    );

    assign ps_out = t_pside'(pside_o);
    assign p      = ps_out.msb ? DataW'(pq << 1) : pq;

    logic             r13_vld, r13_fault;
    logic [DataW-1:0] r13_p, r13_sq, r13_m7;
    logic [15:0]      r13_t;

    always_ff @(posedge i_clk) begin
        r13_p     <= p;
        r13_sq    <= asr(p, 8) * asr(p, 8);
        r13_m7    <= KNeg7357 * p;
        r13_t     <= ps_out.temp;
        r13_fault <= ps_out.fault;
        if (!i_rst_n) begin
            r13_vld <= 1'b0;
        end else begin
            r13_vld <= pdv_vld;
        end
    end

    logic             r14_vld, r14_fault;
    logic [DataW-1:0] r14_p, r14_m3, r14_m7;
    logic [15:0]      r14_t;

    always_ff @(posedge i_clk) begin
        r14_m3    <= r13_sq * K3038;
        r14_m7    <= r13_m7;
        r14_p     <= r13_p;
        r14_t     <= r13_t;
        r14_fault <= r13_fault;
        if (!i_rst_n) begin
            r14_vld <= 1'b0;
        end else begin
            r14_vld <= r13_vld;
        end
    end

    logic             r15_vld, r15_fault;
    logic [DataW-1:0] r15_p, r15_sum;
    logic [15:0]      r15_t;

    always_ff @(posedge i_clk) begin
        r15_sum   <= asr(r14_m3, 16) + asr(r14_m7, 16) + K3791;
        r15_p     <= r14_p;
        r15_t     <= r14_t;
        r15_fault <= r14_fault;
        if (!i_rst_n) begin
            r15_vld <= 1'b0;
        end else begin
            r15_vld <= r14_vld;
        end
    end

    // output register
    logic             r_out_vld, r_out_fault;
    logic [15:0]      r_out_t;
    logic [17:0]      r_out_p, sat_p;
    logic [DataW-1:0] pr;

    assign pr = r15_p + asr(r15_sum, 4);

    always_comb begin
        if (pr[DataW-1]) begin
            sat_p = '0;
        end else if (pr > 32'd262143) begin
            sat_p = '1;
        end else begin
            sat_p = pr[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_t     <= r15_fault ? '0 : r15_t;
        r_out_p     <= r15_fault ? '0 : sat_p;
        r_out_fault <= r15_fault;
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r15_vld;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_temperature_centi = $signed(r_out_t);
    assign o_pressure_pa       = r_out_p;
    assign o_divide_fault      = r_out_fault;

endmodule

@@ tb/sv/barometric_pressure_compensation_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_checker
// Watches the config, input and result channels of the compensation block,
// computes the expected temperature, pressure and fault flag of each item
// and compares every result field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_checker import bpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [15:0]        i_raw_temperature,
    input  logic [23:0]        i_raw_pressure,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [IdxW-1:0]    i_cfg_index,
    input  logic [DataW-1:0]   i_cfg_data,
    input  logic               i_valid,
    input  logic signed [15:0] i_temperature_centi,
    input  logic [17:0]        i_pressure_pa,
    input  logic               i_divide_fault,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_fault_count
);

    typedef struct packed {
        logic signed [15:0] temp;
        logic [17:0]        pres;
        logic               fault;
    } t_reading;

    logic [31:0] cal_word [5];
    logic [1:0]  oss_reg;
    t_reading    expected_readings [$];

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
        longint q;
        q = longint'($signed(a)) / longint'($signed(b));
        return q[31:0];
    endfunction

    function automatic t_reading compensate(input logic [15:0] ut, input logic [23:0] up);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, p, sq, dv, pr, tv, tmp;
        t_reading r;
        ac1 = sx16(cal_word[0][31:16]);
        ac2 = sx16(cal_word[0][15:0]);
        ac3 = sx16(cal_word[1][31:16]);
        ac4 = zx16(cal_word[1][15:0]);
        ac5 = zx16(cal_word[2][31:16]);
        ac6 = zx16(cal_word[2][15:0]);
        b1  = sx16(cal_word[3][31:16]);
        b2  = sx16(cal_word[3][15:0]);
        mc  = sx16(cal_word[4][31:16]);
        md  = sx16(cal_word[4][15:0]);
        r = '{temp: '0, pres: '0, fault: 1'b1};
        x1 = asr((({16'b0, ut} - ac6) * ac5), 15);
        dv = x1 + md;
        if (dv == 0) return r;
        x2 = sdiv(mc * 32'd2048, dv);
        b5 = x1 + x2;
        tv = asr(b5 * 32'd10 + 32'd8, 4);
        b6 = b5 - 32'd4000;
        sq = asr(b6 * b6, 12);
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        tmp = (ac1 * 32'd4 + x3) << oss_reg;
        b3 = sdiv(tmp + 32'd2, 32'd4);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = (({8'b0, up} >> (8 - oss_reg)) - b3) * (32'd50000 >> oss_reg);
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * 32'd3038, 16);
        x2 = asr(32'hFFFF_E343 * p, 16);
        pr = p + asr(x1 + x2 + 32'd3791, 4);
        r.fault = 1'b0;
        if ($signed(tv) > 32767) r.temp = 16'sh7FFF;
        else if ($signed(tv) < -32768) r.temp = 16'sh8000;
        else r.temp = tv[15:0];
        if ($signed(pr) < 0) r.pres = '0;
        else if ($signed(pr) > 262143) r.pres = 18'h3FFFF;
        else r.pres = pr[17:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            foreach (cal_word[i]) cal_word[i] <= '0;
            oss_reg <= OssReset;
            o_fail_count <= 0;
            o_fault_count <= 0;
            expected_readings.delete();
        end else begin
            if (i_valid) begin
                if (expected_readings.size() == 0) begin
                    $error("unexpected result item");
                    errs++;
                end else begin
                    want = expected_readings.pop_front();
                    if (i_temperature_centi !== want.temp) begin
                        $error("temperature_centi expected %0d actual %0d",
                               want.temp, i_temperature_centi);
                        errs++;
                    end
                    if (i_pressure_pa !== want.pres) begin
                        $error("pressure_pa expected %0d actual %0d",
                               want.pres, i_pressure_pa);
                        errs++;
                    end
                    if (i_divide_fault !== want.fault) begin
                        $error("divide_fault expected %0d actual %0d",
                               want.fault, i_divide_fault);
                        errs++;
                    end
                    if (want.fault) o_fault_count <= o_fault_count + 1;
                end
            end
            o_fail_count <= o_fail_count + errs;
            if (i_start && !i_busy)
                expected_readings.push_back(compensate(i_raw_temperature, i_raw_pressure));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index < RegOss) cal_word[i_cfg_index] <= i_cfg_data;
                else if (i_cfg_index == RegOss) oss_reg <= i_cfg_data[1:0];
            end
        end
    end

    assign o_pending = expected_readings.size();

endmodule

@@ tb/sv/barometric_pressure_compensation_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_test
// Drives calibration phases and raw sensor items into the compensation block
// with bursty timing, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_test import bpc_pkg::*;;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 100;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [15:0]        i_raw_temperature = '0;
    logic [23:0]        i_raw_pressure = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [IdxW-1:0]    i_cfg_index = '0;
    logic [DataW-1:0]   i_cfg_data = '0;
    logic               o_valid;
    logic signed [15:0] o_temperature_centi;
    logic [17:0]        o_pressure_pa;
    logic               o_divide_fault;
    int                 fail_count;
    int                 pending;
    int                 fault_count;
    int                 idle_cycles = 0;
    int                 items_sent = 0;
    int                 phases_run = 0;

    always #10 i_clk = ~i_clk;

    barometric_pressure_compensation DUT (.*);

    barometric_pressure_compensation_checker checker_0 (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_raw_temperature,
        .i_raw_pressure, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_valid(o_valid), .i_temperature_centi(o_temperature_centi),
        .i_pressure_pa(o_pressure_pa), .i_divide_fault(o_divide_fault),
        .o_fail_count(fail_count), .o_pending(pending), .o_fault_count(fault_count)
    );

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || (i_cfg_valid && o_cfg_ready) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("timeout after %0d items", items_sent);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // typical factory calibration, with a random spread, random words or extreme words by mode
    task automatic load_calibration(input int mode, input logic [1:0] oss);
        logic [15:0] w [10];
        w = '{16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757,
              16'd23153, 16'd6190, 16'd4, -16'sd8711, 16'd2868};
        if (mode == 1) foreach (w[i]) w[i] = w[i] + 16'($urandom_range(0, 64)) - 16'd32;
        else if (mode == 2) foreach (w[i]) w[i] = 16'($urandom);
        else if (mode == 3) foreach (w[i]) w[i] = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h8000;
        else if (mode == 4) foreach (w[i]) w[i] = ($urandom_range(0, 1)) ? 16'h7FFF : 16'h0000;
        write_reg(RegAc1Ac2, {w[0], w[1]});
        write_reg(RegAc3Ac4, {w[2], w[3]});
        write_reg(RegAc5Ac6, {w[4], w[5]});
        write_reg(RegB1B2,   {w[6], w[7]});
        write_reg(RegMcMd,   {w[8], w[9]});
        write_reg(RegOss,    {30'($urandom), oss});
        write_reg(3'd6, $urandom);
        phases_run++;
    endtask

    task automatic send_item(input logic [15:0] ut, input logic [23:0] up);
        i_start <= 1'b1;
        i_raw_temperature <= ut;
        i_raw_pressure <= up;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic random_burst(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && left > 0; k++) begin
                if ($urandom_range(0, 3) != 0)
                    send_item(16'($urandom_range(24000, 33000)),
                              24'($urandom_range(6000000, 11000000)));
                else
                    send_item(16'($urandom), 24'($urandom));
                left--;
            end
            if ($urandom_range(0, 2) == 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        i_start <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration is all zero: temperature divisor zero
        send_item(16'd0, 24'd0);
        send_item(16'hFFFF, 24'hFFFFFF);
        i_start <= 1'b0;
        drain();

        load_calibration(0, 2'd3);
        send_item(16'd27898, 24'd23843 << 5);
        send_item(16'd0, 24'd0);
        send_item(16'hFFFF, 24'hFFFFFF);
        send_item(16'h8000, 24'h800000);
        send_item(16'h7FFF, 24'h7FFFFF);
        send_item(16'd1, 24'd1);
        i_start <= 1'b0;
        drain();

        // md zero and x1 zero at ut == ac6: zero temperature divisor
        write_reg(RegMcMd, 32'hDDF9_0000);
        send_item(16'd23153, 24'd6000000);
        i_start <= 1'b0;
        drain();

        // ac4 zero: zero pressure divisor
        write_reg(RegMcMd, {16'hDDF9, 16'd2868});
        write_reg(RegAc3Ac4, 32'hC7D1_0000);
        send_item(16'd27898, 24'd6000000);
        send_item(16'hFFFF, 24'd0);
        i_start <= 1'b0;
        drain();

        for (int oss = 0; oss < 4; oss++) begin
            load_calibration(0, 2'(oss));
            send_item(16'd27898, 24'd0);
            send_item(16'd27898, 24'hFFFFFF);
            send_item(16'd0, 24'h123456);
            i_start <= 1'b0;
            drain();
        end

        for (int ph = 0; ph < 10; ph++) begin
            load_calibration((ph < 5) ? 1 : ph % 5, 2'($urandom));
            random_burst(52);
            drain();
        end

        $display("covered %0d items over %0d calibration phases, %0d divide faults",
                 items_sent, phases_run, fault_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
